FILE: sv/hsv8_pkg.sv
// Constants and types for the 8-bit HSV to RGB converter.
// No dependencies; the top level refers to everything here by scoped name.
package hsv8_pkg;

    typedef logic [7:0] t_level;
    typedef logic [2:0] t_sector;

    // Sector boundaries on the hue circle (sectors 0 to 5 span 42 hue codes each; 252..255 is a short wrap sector)
    localparam logic [7:0] SECTOR_SPAN = 8'd42;

    // Fraction within a sector, round(rem * 255 / 42), for rem = 0..41
    localparam logic [7:0] FRAC_TABLE [0:41] = '{
        8'd0,   8'd6,   8'd12,  8'd18,  8'd24,  8'd30,  8'd36,  8'd43,
        8'd49,  8'd55,  8'd61,  8'd67,  8'd73,  8'd79,  8'd85,  8'd91,
        8'd97,  8'd103, 8'd109, 8'd115, 8'd121, 8'd128, 8'd134, 8'd140,
        8'd146, 8'd152, 8'd158, 8'd164, 8'd170, 8'd176, 8'd182, 8'd188,
        8'd194, 8'd200, 8'd206, 8'd213, 8'd219, 8'd225, 8'd231, 8'd237,
        8'd243, 8'd249
    };

    localparam logic [7:0]  FULL_SCALE    = 8'd255;
    localparam logic [15:0] FULL_SCALE_SQ = 16'd65025;

    // Half divisors for round-to-nearest
    localparam logic [15:0] HALF_SCALE    = 16'd127;
    localparam logic [23:0] HALF_SCALE_SQ = 24'd32512;

    // Reciprocals: floor(2^24 / 255) and floor(2^32 / 65025)
    localparam logic [16:0] RECIP_SCALE    = 17'd65793;
    localparam logic [16:0] RECIP_SCALE_SQ = 17'd66051;

endpackage

FILE: sv/hsv_to_rgb_8bit.sv
// HSV to RGB converter, 8 bits per channel, five-stage pipeline.
// Depends on hsv8_pkg (fraction table, reciprocal constants, level types).
//
//  channel | valid    | stall    | payload
//  --------+----------+----------+------------------------------------
//  input   | i_valid  | o_stall  | i_hue, i_saturation, i_brightness
//  output  | o_valid  | i_stall  | o_red, o_green, o_blue
//
// One triple enters per cycle while o_stall is low.
// Stage depth is set by the 24x17 reciprocal multiply and its correction.
// A stage advances when it is empty or the next one moves, so bubbles close
// up under output stall; o_stall rises only when all five stages are full.
// Reset (synchronous, active low) clears the stage valid bits.
module hsv_to_rgb_8bit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_hue,
    input  logic [7:0] i_saturation,
    input  logic [7:0] i_brightness,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);

    logic [5:1] r_vld;
    logic [5:1] en;

    always_comb begin
        en[5] = !r_vld[5] || !i_stall;
        en[4] = !r_vld[4] || en[5];
        en[3] = !r_vld[3] || en[4];
        en[2] = !r_vld[2] || en[3];
        en[1] = !r_vld[1] || en[2];
    end

    assign o_stall = !en[1];
    assign o_valid = r_vld[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) r_vld[1] <= i_valid;
            if (en[2]) r_vld[2] <= r_vld[1];
            if (en[3]) r_vld[3] <= r_vld[2];
            if (en[4]) r_vld[4] <= r_vld[3];
            if (en[5]) r_vld[5] <= r_vld[4];
        end
    end

    // ---------------- stage 1: sector, fraction, s*v ----------------
    hsv8_pkg::t_sector n1_sec;
    logic [7:0]        n1_base;
    logic [7:0]        n1_rem8;
    logic [5:0]        n1_rem;

    always_comb begin
        if (i_hue >= 8'd252) begin
            n1_sec = 3'd6; n1_base = 8'd252;
        end else if (i_hue >= 8'd210) begin
            n1_sec = 3'd5; n1_base = 8'd210;
        end else if (i_hue >= 8'd168) begin
            n1_sec = 3'd4; n1_base = 8'd168;
        end else if (i_hue >= 8'd126) begin
            n1_sec = 3'd3; n1_base = 8'd126;
        end else if (i_hue >= 8'd84) begin
            n1_sec = 3'd2; n1_base = 8'd84;
        end else if (i_hue >= hsv8_pkg::SECTOR_SPAN) begin
            n1_sec = 3'd1; n1_base = hsv8_pkg::SECTOR_SPAN;
        end else begin
            n1_sec = 3'd0; n1_base = 8'd0;
        end
        n1_rem8 = i_hue - n1_base;
        n1_rem  = n1_rem8[5:0];
    end

    hsv8_pkg::t_sector r1_sec;
    logic [7:0]        r1_f;
    logic [15:0]       r1_sv;
    hsv8_pkg::t_level  r1_v;
    logic              r1_blk;
    logic              r1_gry;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_sec <= n1_sec;
            r1_f   <= hsv8_pkg::FRAC_TABLE[n1_rem];
            r1_sv  <= i_saturation * i_brightness;
            r1_v   <= i_brightness;
            r1_blk <= (i_brightness == 8'd0);
            r1_gry <= (i_saturation == 8'd0);
        end
    end

    // ---------------- stage 2: f*s*v, (255-f)*s*v, estimate s*v/255 ----
    logic [7:0]  n2_g;
    logic [15:0] n2_pn;

    assign n2_g  = hsv8_pkg::FULL_SCALE - r1_f;
    assign n2_pn = r1_sv + hsv8_pkg::HALF_SCALE;

    hsv8_pkg::t_sector r2_sec;
    hsv8_pkg::t_level  r2_v;
    logic              r2_blk;
    logic              r2_gry;
    logic [23:0]       r2_fsv;
    logic [23:0]       r2_gsv;
    logic [15:0]       r2_pn;
    logic [32:0]       r2_pm;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_sec <= r1_sec;
            r2_v   <= r1_v;
            r2_blk <= r1_blk;
            r2_gry <= r1_gry;
            r2_fsv <= r1_f * r1_sv;
            r2_gsv <= n2_g * r1_sv;
            r2_pn  <= n2_pn;
            r2_pm  <= n2_pn * hsv8_pkg::RECIP_SCALE;
        end
    end

    // ---------------- stage 3: correct p, estimate q and t ----------------
    logic [8:0]  n3_pq0;
    logic [16:0] n3_prem;
    logic [8:0]  n3_pq;
    logic [23:0] n3_qn;
    logic [23:0] n3_tn;

    always_comb begin
        n3_pq0  = r2_pm[32:24];
        n3_prem = {1'b0, r2_pn} - (n3_pq0 * hsv8_pkg::FULL_SCALE);
        // estimate is at most one low
        n3_pq   = (n3_prem >= 17'(hsv8_pkg::FULL_SCALE)) ? n3_pq0 + 9'd1 : n3_pq0;
        n3_qn   = r2_fsv + hsv8_pkg::HALF_SCALE_SQ;
        n3_tn   = r2_gsv + hsv8_pkg::HALF_SCALE_SQ;
    end

    hsv8_pkg::t_sector r3_sec;
    hsv8_pkg::t_level  r3_v;
    logic              r3_blk;
    logic              r3_gry;
    hsv8_pkg::t_level  r3_p;
    logic [23:0]       r3_qn;
    logic [23:0]       r3_tn;
    logic [40:0]       r3_qm;
    logic [40:0]       r3_tm;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_sec <= r2_sec;
            r3_v   <= r2_v;
            r3_blk <= r2_blk;
            r3_gry <= r2_gry;
            r3_p   <= r2_v - n3_pq[7:0];
            r3_qn  <= n3_qn;
            r3_tn  <= n3_tn;
            r3_qm  <= n3_qn * hsv8_pkg::RECIP_SCALE_SQ;
            r3_tm  <= n3_tn * hsv8_pkg::RECIP_SCALE_SQ;
        end
    end

    // ---------------- stage 4: correct q and t quotients ----------------
    logic [8:0]  n4_qq0;
    logic [8:0]  n4_tq0;
    logic [24:0] n4_qrem;
    logic [24:0] n4_trem;
    logic [8:0]  n4_qq;
    logic [8:0]  n4_tq;

    always_comb begin
        n4_qq0  = r3_qm[40:32];
        n4_tq0  = r3_tm[40:32];
        n4_qrem = {1'b0, r3_qn} - 25'(n4_qq0 * hsv8_pkg::FULL_SCALE_SQ);
        n4_trem = {1'b0, r3_tn} - 25'(n4_tq0 * hsv8_pkg::FULL_SCALE_SQ);
        n4_qq   = (n4_qrem >= 25'(hsv8_pkg::FULL_SCALE_SQ)) ? n4_qq0 + 9'd1 : n4_qq0;
        n4_tq   = (n4_trem >= 25'(hsv8_pkg::FULL_SCALE_SQ)) ? n4_tq0 + 9'd1 : n4_tq0;
    end

    hsv8_pkg::t_sector r4_sec;
    hsv8_pkg::t_level  r4_v;
    logic              r4_blk;
    logic              r4_gry;
    hsv8_pkg::t_level  r4_p;
    hsv8_pkg::t_level  r4_qd;
    hsv8_pkg::t_level  r4_td;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_sec <= r3_sec;
            r4_v   <= r3_v;
            r4_blk <= r3_blk;
            r4_gry <= r3_gry;
            r4_p   <= r3_p;
            r4_qd  <= n4_qq[7:0];
            r4_td  <= n4_tq[7:0];
        end
    end

    // ---------------- stage 5: levels and channel pattern ----------------
    hsv8_pkg::t_level n5_q;
    hsv8_pkg::t_level n5_t;
    hsv8_pkg::t_level n5_r;
    hsv8_pkg::t_level n5_g;
    hsv8_pkg::t_level n5_b;

    always_comb begin
        n5_q = r4_v - r4_qd;
        n5_t = r4_v - r4_td;
        if (r4_blk) begin
            n5_r = 8'd0; n5_g = 8'd0; n5_b = 8'd0;
        end else if (r4_gry) begin
            n5_r = r4_v; n5_g = r4_v; n5_b = r4_v;
        end else begin
            case (r4_sec)
                3'd1: begin n5_r = n5_q; n5_g = r4_v; n5_b = r4_p; end
                3'd2: begin n5_r = r4_p; n5_g = r4_v; n5_b = n5_t; end
                3'd3: begin n5_r = r4_p; n5_g = n5_q; n5_b = r4_v; end
                3'd4: begin n5_r = n5_t; n5_g = r4_p; n5_b = r4_v; end
                3'd5: begin n5_r = r4_v; n5_g = r4_p; n5_b = n5_q; end
                // sector 0, and the wrapped top of the hue circle
                default: begin n5_r = r4_v; n5_g = n5_t; n5_b = r4_p; end
            endcase
        end
    end

    hsv8_pkg::t_level r_red;
    hsv8_pkg::t_level r_green;
    hsv8_pkg::t_level r_blue;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_red   <= n5_r;
            r_green <= n5_g;
            r_blue  <= n5_b;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    // ---------------- assertions ----------------
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_vld == 5'b11111))
        else $error("upstream stalled while a stage is empty");

    a_levels_below_v: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> (r4_qd <= r4_v && r4_td <= r4_v && r4_p <= r4_v))
        else $error("level offset exceeds brightness");

    a_black_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en[5] && r_vld[4] && r4_blk) |=> (o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0))
        else $error("zero brightness did not give black");

    a_max_is_v: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en[5] && r_vld[4] && !r4_blk) |=>
        (o_red == $past(r4_v) || o_green == $past(r4_v) || o_blue == $past(r4_v)))
        else $error("no channel carries the brightness level");

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && en[2]) |=> r_vld[2])
        else $error("beat lost between stage 1 and stage 2");

endmodule

FILE: verif/hsv_to_rgb_8bit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for hsv_to_rgb_8bit: random and corner HSV triples, random idling.
// Depends on hsv8_pkg (level type) and the hsv_to_rgb_8bit top level.
module hsv_to_rgb_8bit_tb;

    typedef hsv8_pkg::t_level t_level;

    typedef struct packed {
        t_level red;
        t_level green;
        t_level blue;
    } t_rgb_pixel;

    typedef struct packed {
        t_level hue;
        t_level sat;
        t_level val;
    } t_hsv_triple;

    // Hue sectors, named by the color at their start
    typedef enum int unsigned {
        SEC_RED     = 0,
        SEC_YELLOW  = 1,
        SEC_GREEN   = 2,
        SEC_CYAN    = 3,
        SEC_BLUE    = 4,
        SEC_MAGENTA = 5
    } t_hue_sector;

    localparam int unsigned HUE_SPAN      = 42;
    localparam int unsigned LEVEL_MAX     = 255;
    localparam int unsigned LEVEL_MAX_SQ  = 255 * 255;
    localparam int unsigned RUN_LIMIT     = 500000;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned PIPE_DEPTH    = 5;
    localparam int          RANDOM_PHASES = 7;
    localparam int          PHASE_ITEMS   = 250;

    class t_rgb_scoreboard;
        t_rgb_pixel  expected_rgb[$];
        t_hsv_triple source_hsv[$];
        int          mismatches = 0;

        function t_rgb_pixel predict_rgb(t_level hue, t_level sat, t_level val);
            int unsigned h, s, v, f, p, q, t;
            t_rgb_pixel  px;
            h = 32'(hue);
            s = 32'(sat);
            v = 32'(val);
            if (v == 0) begin
                px = '{8'd0, 8'd0, 8'd0};
            end else if (s == 0) begin
                px = '{val, val, val};
            end else begin
                f = ((h % HUE_SPAN) * LEVEL_MAX + HUE_SPAN / 2) / HUE_SPAN;
                p = v - (s * v + LEVEL_MAX / 2) / LEVEL_MAX;
                q = v - (f * s * v + LEVEL_MAX_SQ / 2) / LEVEL_MAX_SQ;
                t = v - ((LEVEL_MAX - f) * s * v + LEVEL_MAX_SQ / 2) / LEVEL_MAX_SQ;
                // hue 252..255 falls past the last sector and wraps to red
                case (h / HUE_SPAN)
                    SEC_YELLOW:  px = '{q[7:0], val, p[7:0]};
                    SEC_GREEN:   px = '{p[7:0], val, t[7:0]};
                    SEC_CYAN:    px = '{p[7:0], q[7:0], val};
                    SEC_BLUE:    px = '{t[7:0], p[7:0], val};
                    SEC_MAGENTA: px = '{val, p[7:0], q[7:0]};
                    default:     px = '{val, t[7:0], p[7:0]};
                endcase
            end
            return px;
        endfunction

        function void note_triple(t_level hue, t_level sat, t_level val);
            expected_rgb.push_back(predict_rgb(hue, sat, val));
            source_hsv.push_back('{hue, sat, val});
        endfunction

        function int pending();
            return expected_rgb.size();
        endfunction

        task report_mismatch(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_pixel(t_level red, t_level green, t_level blue);
            t_rgb_pixel  want;
            t_hsv_triple src;
            if (expected_rgb.size() == 0) begin
                report_mismatch($sformatf("unexpected beat rgb=%0d,%0d,%0d", red, green, blue));
            end else begin
                want = expected_rgb.pop_front();
                src  = source_hsv.pop_front();
                if (red !== want.red)
                    report_mismatch($sformatf("hsv=%0d,%0d,%0d red %0d want %0d",
                        src.hue, src.sat, src.val, red, want.red));
                if (green !== want.green)
                    report_mismatch($sformatf("hsv=%0d,%0d,%0d green %0d want %0d",
                        src.hue, src.sat, src.val, green, want.green));
                if (blue !== want.blue)
                    report_mismatch($sformatf("hsv=%0d,%0d,%0d blue %0d want %0d",
                        src.hue, src.sat, src.val, blue, want.blue));
            end
        endtask
    endclass

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_hue        = '0;
    logic [7:0] i_saturation = '0;
    logic [7:0] i_brightness = '0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_red;
    logic [7:0] o_green;
    logic [7:0] o_blue;

    t_rgb_scoreboard sb = new();

    bit          calm_phase    = 1'b0;
    bit          long_hold_req = 1'b0;
    int unsigned cycle_count   = 0;
    int unsigned seg_left      = 0;
    bit          seg_stall     = 1'b0;

    hsv_to_rgb_8bit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("hsv_to_rgb_8bit_tb NOT OK");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic t_level rand_level();
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0:       return 8'd0;
                1:       return 8'd1;
                2:       return 8'd254;
                default: return 8'd255;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // bias some hues onto sector edges and into the wrap range
    function automatic t_level rand_hue();
        int unsigned k;
        if ($urandom_range(0, 6) == 0) begin
            k = $urandom_range(0, 6);
            if ($urandom_range(0, 1) == 0)
                return 8'(k * HUE_SPAN);
            else if (k == 6)
                return 8'($urandom_range(252, 255));
            else
                return 8'(k * HUE_SPAN + HUE_SPAN - 1);
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Receiver: random stall runs, plus one long hold on request
    always @(posedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            seg_stall     = 1'b1;
            seg_left      = LONG_HOLD;
        end else if (seg_left == 0) begin
            seg_stall = calm_phase ? 1'b0 : ($urandom_range(0, 2) == 0);
            seg_left  = calm_phase ? 1 : gap_len() + 1;
        end
        seg_left--;
        i_stall <= seg_stall;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_triple(i_hue, i_saturation, i_brightness);
            if (o_valid && !i_stall)
                sb.check_pixel(o_red, o_green, o_blue);
        end
    end

    task automatic send_triple(input t_level hue, input t_level sat, input t_level val);
        i_valid      <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_brightness <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic idle_input(input int unsigned n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_triple(rand_hue(), rand_level(), rand_level());
            if (!calm_phase)
                idle_input(gap_len());
        end
    endtask

    t_hsv_triple corner_cases [24] = '{
        '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd0},   '{8'd100, 8'd17,  8'd0},
        '{8'd0,   8'd0,   8'd255}, '{8'd77,  8'd0,   8'd1},   '{8'd255, 8'd0,   8'd128},
        '{8'd0,   8'd255, 8'd255}, '{8'd41,  8'd255, 8'd255}, '{8'd42,  8'd255, 8'd255},
        '{8'd83,  8'd255, 8'd255}, '{8'd84,  8'd255, 8'd255}, '{8'd125, 8'd255, 8'd255},
        '{8'd126, 8'd255, 8'd255}, '{8'd167, 8'd255, 8'd255}, '{8'd168, 8'd255, 8'd255},
        '{8'd209, 8'd255, 8'd255}, '{8'd210, 8'd255, 8'd255}, '{8'd251, 8'd255, 8'd255},
        '{8'd252, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255}, '{8'd21,  8'd1,   8'd1},
        '{8'd200, 8'd128, 8'd200}, '{8'd254, 8'd1,   8'd255}, '{8'd30,  8'd255, 8'd1}
    };

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_cases[i]) begin
            send_triple(corner_cases[i].hue, corner_cases[i].sat, corner_cases[i].val);
            idle_input(gap_len());
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            calm_phase = (ph == 2);
            if (ph == 4) begin
                // hold the output and keep offering beats until the pipe backs up
                long_hold_req = 1'b1;
                for (int i = 0; i < 40; i++)
                    send_triple(rand_hue(), rand_level(), rand_level());
            end
            send_random(PHASE_ITEMS);
            if (ph == 3)
                wait_all_results();
        end
        calm_phase = 1'b0;

        wait_all_results();
        repeat (PIPE_DEPTH * 4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("hsv_to_rgb_8bit_tb OK");
        else
            $display("hsv_to_rgb_8bit_tb NOT OK");
        $finish;
    end

endmodule
